### rtl/core/ihw_pkg.sv
// ----------------------------------------------------------------------------
// ihw_pkg
// Shared types, codes and helpers of the hex record writer.
// ----------------------------------------------------------------------------
package ihw_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [2:0] OP_DATA_START = 3'd0;
    localparam logic [2:0] OP_DATA_BYTE  = 3'd1;
    localparam logic [2:0] OP_EXEC_START = 3'd2;
    localparam logic [2:0] OP_FINISH     = 3'd3;
    localparam logic [2:0] OP_IGNORE     = 3'd4;

    localparam logic [1:0] CFG_SEGMENTED = 2'd0;
    localparam logic [1:0] CFG_START_EN  = 2'd1;
    localparam logic [1:0] CFG_FOOTER_EN = 2'd2;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ESA  = 8'h02;
    localparam logic [7:0] REC_SSA  = 8'h03;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    localparam logic [6:0] CH_COLON   = 7'h3A;
    localparam logic [6:0] CH_NEWLINE = 7'h0A;
    localparam logic [6:0] CH_NUL     = 7'h00;

    // One line fragment: optional ':' and sum reset, bytes, optional checksum and newline
    typedef struct packed {
        logic            err;
        logic            open;
        logic            close;
        logic            last;
        logic [2:0]      nb_m1;
        logic [7:0][7:0] bytes;
    } entry_t;

    typedef enum logic [0:0] {
        FR_RUN,
        FR_HEAD
    } fr_state_t;

    typedef enum logic [2:0] {
        PH_COLON,
        PH_HI,
        PH_LO,
        PH_CKHI,
        PH_CKLO,
        PH_NL,
        PH_ERR
    } phase_t;

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10)
        begin
            c = 7'h30 + {3'b000, n};
        end
        else
        begin
            c = 7'h37 + {3'b000, n};
        end
        return c;
    endfunction

endpackage

### rtl/core/ihw_front.sv
// ----------------------------------------------------------------------------
// ihw_front
// Accepts input items, tracks base address and record length, and queues
// line fragments for the back end.
// ----------------------------------------------------------------------------
module ihw_front
    import ihw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output entry_t      q_entry
);

    fr_state_t   st_reg, st_next;
    logic        seg_reg, start_en_reg, footer_en_reg;
    logic [15:0] ua_reg, ua_next;
    logic        uv_reg, uv_next;
    logic [7:0]  bl_reg, bl_next;
    logic [7:0]  hold_len_reg, hold_len_next;
    logic [15:0] hold_addr_reg, hold_addr_next;

    logic [2:0]  op;
    logic [31:0] addr;
    logic [7:0]  len;
    logic [7:0]  db;
    logic [15:0] up;
    logic        acc;
    logic        need_base;
    logic        seg_bad;

    assign op   = s_tuser;
    assign addr = s_tdata[31:0];
    assign len  = s_tdata[39:32];
    assign db   = s_tdata[47:40];
    assign up   = addr[31:16];

    assign s_tready  = (st_reg == FR_RUN) && !q_full;
    assign acc       = s_tvalid && s_tready;
    assign need_base = !uv_reg || (up != ua_reg);
    assign seg_bad   = seg_reg && (up[15:4] != 12'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= 1'b0;
            start_en_reg  <= 1'b1;
            footer_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEGMENTED: seg_reg       <= cfg_data;
                CFG_START_EN:  start_en_reg  <= cfg_data;
                CFG_FOOTER_EN: footer_en_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= FR_RUN;
            ua_reg        <= '0;
            uv_reg        <= 1'b0;
            bl_reg        <= '0;
            hold_len_reg  <= '0;
            hold_addr_reg <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            ua_reg        <= ua_next;
            uv_reg        <= uv_next;
            bl_reg        <= bl_next;
            hold_len_reg  <= hold_len_next;
            hold_addr_reg <= hold_addr_next;
        end
    end

    always_comb
    begin
        st_next        = st_reg;
        ua_next        = ua_reg;
        uv_next        = uv_reg;
        bl_next        = bl_reg;
        hold_len_next  = hold_len_reg;
        hold_addr_next = hold_addr_reg;
        q_push         = 1'b0;
        q_entry        = '0;

        case (st_reg)
            FR_RUN:
            begin
                if (acc)
                begin
                    case (op)
                        OP_DATA_START:
                        begin
                            q_push = 1'b1;
                            if (need_base && seg_bad)
                            begin
                                q_entry.err  = 1'b1;
                                q_entry.last = 1'b1;
                                bl_next      = '0;
                            end
                            else if (need_base)
                            begin
                                ua_next        = up;
                                uv_next        = 1'b1;
                                bl_next        = len;
                                hold_len_next  = len;
                                hold_addr_next = addr[15:0];
                                st_next        = FR_HEAD;
                                q_entry.open     = 1'b1;
                                q_entry.close    = 1'b1;
                                q_entry.nb_m1    = 3'd5;
                                q_entry.bytes[0] = 8'h02;
                                if (seg_reg)
                                begin
                                    q_entry.bytes[3] = REC_ESA;
                                    q_entry.bytes[4] = {up[3:0], 4'h0};
                                end
                                else
                                begin
                                    q_entry.bytes[3] = REC_ELA;
                                    q_entry.bytes[4] = up[15:8];
                                    q_entry.bytes[5] = up[7:0];
                                end
                            end
                            else
                            begin
                                bl_next          = len;
                                q_entry.open     = 1'b1;
                                q_entry.close    = (len == 8'd0);
                                q_entry.last     = 1'b1;
                                q_entry.nb_m1    = 3'd3;
                                q_entry.bytes[0] = len;
                                q_entry.bytes[1] = addr[15:8];
                                q_entry.bytes[2] = addr[7:0];
                                q_entry.bytes[3] = REC_DATA;
                            end
                        end
                        OP_DATA_BYTE:
                        begin
                            if (bl_reg != 8'd0)
                            begin
                                q_push           = 1'b1;
                                bl_next          = bl_reg - 8'd1;
                                q_entry.close    = (bl_reg == 8'd1);
                                q_entry.last     = 1'b1;
                                q_entry.bytes[0] = db;
                            end
                        end
                        OP_EXEC_START:
                        begin
                            if (start_en_reg)
                            begin
                                q_push           = 1'b1;
                                q_entry.open     = 1'b1;
                                q_entry.close    = 1'b1;
                                q_entry.last     = 1'b1;
                                q_entry.nb_m1    = 3'd7;
                                q_entry.bytes[0] = 8'h04;
                                q_entry.bytes[3] = seg_reg ? REC_SSA : REC_SLA;
                                q_entry.bytes[4] = addr[31:24];
                                q_entry.bytes[5] = addr[23:16];
                                q_entry.bytes[6] = addr[15:8];
                                q_entry.bytes[7] = addr[7:0];
                            end
                        end
                        OP_FINISH:
                        begin
                            uv_next = 1'b0;
                            bl_next = '0;
                            if (footer_en_reg)
                            begin
                                q_push           = 1'b1;
                                q_entry.open     = 1'b1;
                                q_entry.close    = 1'b1;
                                q_entry.last     = 1'b1;
                                q_entry.nb_m1    = 3'd3;
                                q_entry.bytes[3] = REC_EOF;
                            end
                        end
                        OP_IGNORE: ;
                        default:
                        begin
                            q_push       = 1'b1;
                            q_entry.err  = 1'b1;
                            q_entry.last = 1'b1;
                        end
                    endcase
                end
            end
            FR_HEAD:
            begin
                if (!q_full)
                begin
                    q_push           = 1'b1;
                    st_next          = FR_RUN;
                    q_entry.open     = 1'b1;
                    q_entry.close    = (hold_len_reg == 8'd0);
                    q_entry.last     = 1'b1;
                    q_entry.nb_m1    = 3'd3;
                    q_entry.bytes[0] = hold_len_reg;
                    q_entry.bytes[1] = hold_addr_reg[15:8];
                    q_entry.bytes[2] = hold_addr_reg[7:0];
                    q_entry.bytes[3] = REC_DATA;
                end
            end
            default: st_next = FR_RUN;
        endcase
    end

endmodule

### rtl/core/ihw_queue.sv
// ----------------------------------------------------------------------------
// ihw_queue
// Short first-in first-out queue of line fragments between front and back.
// ----------------------------------------------------------------------------
module ihw_queue
    import ihw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output entry_t head
);

    entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (cnt_reg == (QAW+1)'(QDEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + (QAW+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (QAW+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### rtl/core/ihw_back.sv
// ----------------------------------------------------------------------------
// ihw_back
// Expands queued line fragments into characters, keeps the line checksum,
// and drives the output register.
// ----------------------------------------------------------------------------
module ihw_back
    import ihw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  entry_t     q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    entry_t     cur_reg, cur_next;
    phase_t     ph_reg, ph_next;
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;
    logic       ov_reg, ov_next;
    logic [6:0] och_reg, och_next;
    logic       olast_reg, olast_next;
    logic       oerr_reg, oerr_next;

    logic       adv;
    logic       fin;
    logic [7:0] cur_byte;
    logic [7:0] ck;
    logic [6:0] ch;

    assign adv      = !ov_reg || m_tready;
    assign cur_byte = cur_reg.bytes[idx_reg];
    assign ck       = 8'd0 - sum_reg;

    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, och_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = oerr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            ph_reg    <= PH_COLON;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            ov_reg    <= 1'b0;
            och_reg   <= '0;
            olast_reg <= 1'b0;
            oerr_reg  <= 1'b0;
        end
        else
        begin
            cur_reg   <= cur_next;
            ph_reg    <= ph_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            ov_reg    <= ov_next;
            och_reg   <= och_next;
            olast_reg <= olast_next;
            oerr_reg  <= oerr_next;
        end
    end

    always_comb
    begin
        cur_next   = cur_reg;
        ph_next    = ph_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        ov_next    = ov_reg;
        och_next   = och_reg;
        olast_next = olast_reg;
        oerr_next  = oerr_reg;
        fin        = 1'b0;
        ch         = CH_NUL;
        q_pop      = 1'b0;

        case (ph_reg)
            PH_COLON: ch = CH_COLON;
            PH_HI:    ch = hex_char(cur_byte[7:4]);
            PH_LO:
            begin
                ch  = hex_char(cur_byte[3:0]);
                fin = (idx_reg == cur_reg.nb_m1) && !cur_reg.close;
            end
            PH_CKHI:  ch = hex_char(ck[7:4]);
            PH_CKLO:  ch = hex_char(ck[3:0]);
            PH_NL:
            begin
                ch  = CH_NEWLINE;
                fin = 1'b1;
            end
            PH_ERR:
            begin
                ch  = CH_NUL;
                fin = 1'b1;
            end
            default:  ch = CH_NUL;
        endcase

        if (adv)
        begin
            ov_next = busy_reg;
        end

        if (busy_reg && adv)
        begin
            och_next   = ch;
            olast_next = cur_reg.last && fin;
            oerr_next  = (ph_reg == PH_ERR);
            case (ph_reg)
                PH_COLON:
                begin
                    sum_next = '0;
                    ph_next  = PH_HI;
                end
                PH_HI: ph_next = PH_LO;
                PH_LO:
                begin
                    sum_next = sum_reg + cur_byte;
                    if (idx_reg == cur_reg.nb_m1)
                    begin
                        ph_next = PH_CKHI;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                        ph_next  = PH_HI;
                    end
                end
                PH_CKHI: ph_next = PH_CKLO;
                PH_CKLO:
                begin
                    sum_next = '0;
                    ph_next  = PH_NL;
                end
                default: ph_next = ph_reg;
            endcase
            if (fin)
            begin
                busy_next = 1'b0;
            end
        end

        // load the next fragment when idle or as the current one finishes
        if (q_valid && (!busy_reg || (adv && fin)))
        begin
            q_pop     = 1'b1;
            busy_next = 1'b1;
            cur_next  = q_head;
            idx_next  = '0;
            if (q_head.err)
            begin
                ph_next = PH_ERR;
            end
            else if (q_head.open)
            begin
                ph_next = PH_COLON;
            end
            else
            begin
                ph_next = PH_HI;
            end
        end
    end

endmodule

### rtl/core/intel_hex_record_writer.sv
// Path: an accepted item goes through the fragment queue, the back end's current fragment
// register and the output register. One character per cycle while the sink is ready and
// fragments wait; a data byte item gives 2 characters (5 when it closes the line), any item
// at most 28 (base record and zero-length data head). Input stalls only while the 4-entry
// fragment queue is full, or while the front end still has to queue the data head after
// a base record. Reset: config to defaults, no base sent, queue and output empty.
// ----------------------------------------------------------------------------
// intel_hex_record_writer
// Load-file record stream to hex text, one ASCII character per output item.
// ----------------------------------------------------------------------------
module intel_hex_record_writer
    import ihw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address[31:0], length[39:32], data_byte[47:40]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // text_char[6:0], zero[7]
    output logic        m_tlast,
    output logic        m_tuser    // error[0]
);

    logic   q_full;
    logic   q_push;
    entry_t q_in;
    logic   q_pop;
    logic   q_valid;
    entry_t q_head;

    ihw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    ihw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    ihw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/core/ihw_checker.sv
// ----------------------------------------------------------------------------
// ihw_checker
// Port-level checks of the hex record writer, bound to the top level.
// ----------------------------------------------------------------------------
module ihw_checker
    import ihw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("output valid straight after reset");

    a_err_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == 8'h00) && m_tlast)
        else $error("error item is not a lone terminating item");

    a_colon_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tdata[6:0] == CH_COLON) && !m_tuser |=>
            m_tvalid && !m_tuser
            && (((m_tdata >= 8'h30) && (m_tdata <= 8'h39))
                || ((m_tdata >= 8'h41) && (m_tdata <= 8'h46))))
        else $error("colon not followed at once by a hex digit");

endmodule

bind intel_hex_record_writer ihw_checker u_ihw_checker (.*);

### tb/intel_hex_record_writer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// intel_hex_record_writer_test
// Feeds load-file records to the hex record writer and checks every output
// character, its end-of-item mark and its error flag against a cycle-free
// model of the text that each record must produce. Directed records cover
// the field extremes and the corner cases; random record streams follow
// under several register settings, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module intel_hex_record_writer_test;
    import ihw_pkg::*;

    localparam logic [2:0] OP_RESERVED_5 = 3'd5;
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;
    localparam logic [127:0] HEX_DIGITS  = "0123456789ABCDEF";
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] address;
        logic [7:0]  length;
        logic [7:0]  data_byte;
    } load_record_t;

    typedef struct packed {
        logic [6:0] text_char;
        logic       last;
        logic       err;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_SEGMENTED;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // address[31:0], length[39:32], data_byte[47:40]
    logic [2:0]  s_tuser = '0;     // opcode[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // text_char[6:0], zero[7]
    logic        m_tlast;
    logic        m_tuser;          // error[0]

    load_record_t pending_records[$];
    text_char_t   expected_chars[$];
    text_char_t   head_char;
    load_record_t next_record;
    int           failures = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_mode = 0;
    int           stall_left = 0;
    logic [15:0]  recent_upper = '0;

    // model copy of the registers and the line state
    logic        seg_mode = 1'b0;
    logic        start_en = 1'b1;
    logic        footer_en = 1'b1;
    logic [15:0] base_upper = '0;
    logic        base_valid = 1'b0;
    logic [7:0]  line_sum = '0;
    logic [7:0]  bytes_remaining = '0;
    int          item_chars = 0;

    intel_hex_record_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [6:0] ascii_digit(input logic [3:0] nibble);
        return HEX_DIGITS[8 * (15 - nibble) +: 7];
    endfunction

    function automatic void push_char(input logic [6:0] ch, input logic err);
        text_char_t c;
        c.text_char = ch;
        c.last = 1'b0;
        c.err = err;
        expected_chars.push_back(c);
        item_chars++;
    endfunction

    function automatic void push_hex_byte(input logic [7:0] b);
        line_sum = line_sum + b;
        push_char(ascii_digit(b[7:4]), 1'b0);
        push_char(ascii_digit(b[3:0]), 1'b0);
    endfunction

    function automatic void open_line(input logic [7:0] len, input logic [15:0] addr16,
                                      input logic [7:0] rec_type);
        push_char(CH_COLON, 1'b0);
        line_sum = '0;
        push_hex_byte(len);
        push_hex_byte(addr16[15:8]);
        push_hex_byte(addr16[7:0]);
        push_hex_byte(rec_type);
    endfunction

    function automatic void close_line();
        logic [7:0] check;
        check = 8'h00 - line_sum;
        push_hex_byte(check);
        push_char(CH_NEWLINE, 1'b0);
    endfunction

    function automatic void predict_hex_text(input load_record_t rec);
        logic [15:0] up;
        logic [15:0] payload;
        logic        base_err;
        up = rec.address[31:16];
        base_err = 1'b0;
        item_chars = 0;
        case (rec.opcode)
            OP_DATA_START:
            begin
                if (!base_valid || up != base_upper)
                begin
                    if (seg_mode && up >= 16'h0010)
                    begin
                        bytes_remaining = '0;
                        push_char(CH_NUL, 1'b1);
                        base_err = 1'b1;
                    end
                    else
                    begin
                        base_upper = up;
                        base_valid = 1'b1;
                        payload = seg_mode ? {up[3:0], 12'h000} : up;
                        open_line(8'd2, 16'h0000, seg_mode ? REC_ESA : REC_ELA);
                        push_hex_byte(payload[15:8]);
                        push_hex_byte(payload[7:0]);
                        close_line();
                    end
                end
                if (!base_err)
                begin
                    open_line(rec.length, rec.address[15:0], REC_DATA);
                    bytes_remaining = rec.length;
                    if (rec.length == 8'd0)
                    begin
                        close_line();
                    end
                end
            end
            OP_DATA_BYTE:
            begin
                if (bytes_remaining != 8'd0)
                begin
                    push_hex_byte(rec.data_byte);
                    bytes_remaining = bytes_remaining - 8'd1;
                    if (bytes_remaining == 8'd0)
                    begin
                        close_line();
                    end
                end
            end
            OP_EXEC_START:
            begin
                if (start_en)
                begin
                    open_line(8'd4, 16'h0000, seg_mode ? REC_SSA : REC_SLA);
                    push_hex_byte(rec.address[31:24]);
                    push_hex_byte(rec.address[23:16]);
                    push_hex_byte(rec.address[15:8]);
                    push_hex_byte(rec.address[7:0]);
                    close_line();
                end
            end
            OP_FINISH:
            begin
                if (footer_en)
                begin
                    open_line(8'd0, 16'h0000, REC_EOF);
                    close_line();
                end
                base_valid = 1'b0;
                bytes_remaining = '0;
            end
            OP_IGNORE:
            begin
            end
            default:
            begin
                push_char(CH_NUL, 1'b1);
            end
        endcase
        if (item_chars > 0)
        begin
            expected_chars[expected_chars.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void queue_record(input logic [2:0] op, input logic [31:0] addr,
                                         input logic [7:0] len, input logic [7:0] db);
        load_record_t rec;
        rec.opcode = op;
        rec.address = addr;
        rec.length = len;
        rec.data_byte = db;
        pending_records.push_back(rec);
    endfunction

    function automatic int queue_data_record(input logic [31:0] addr, input int len,
                                             input int nbytes);
        queue_record(OP_DATA_START, addr, 8'(len), 8'($urandom()));
        repeat (nbytes)
        begin
            queue_record(OP_DATA_BYTE, $urandom(), 8'($urandom()), 8'($urandom()));
        end
        return nbytes + 1;
    endfunction

    function automatic logic [31:0] pick_address();
        logic [31:0] addr;
        addr = $urandom();
        case ($urandom_range(0, 3))
            0:
            begin
            end
            1, 2:
            begin
                addr[31:16] = recent_upper;
            end
            default:
            begin
                addr[31:16] = 16'($urandom_range(0, 17));
            end
        endcase
        recent_upper = addr[31:16];
        return addr;
    endfunction

    task automatic queue_random_records(input int count);
        int queued;
        int kind;
        int len;
        int nbytes;
        queued = 0;
        while (queued < count)
        begin
            kind = $urandom_range(0, 19);
            if (kind <= 12)
            begin
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 255)
                                                   : $urandom_range(0, 12);
                nbytes = len;
                if (len > 12 || $urandom_range(0, 9) == 0)
                begin
                    nbytes = $urandom_range(0, (len > 8) ? 8 : len);
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    nbytes = len + 1;
                end
                queued += queue_data_record(pick_address(), len, nbytes);
            end
            else if (kind <= 14)
            begin
                queue_record(OP_EXEC_START, $urandom(), 8'($urandom()), 8'($urandom()));
                queued++;
            end
            else if (kind == 15)
            begin
                queue_record(OP_FINISH, $urandom(), 8'($urandom()), 8'($urandom()));
                queued++;
            end
            else if (kind == 16)
            begin
                queue_record(3'($urandom_range(OP_IGNORE, OP_RESERVED_7)), $urandom(),
                             8'($urandom()), 8'($urandom()));
                queued++;
            end
            else if (kind == 17)
            begin
                queue_record(OP_DATA_BYTE, $urandom(), 8'($urandom()), 8'($urandom()));
                queued++;
            end
            else
            begin
                len = $urandom_range(0, 4);
                queued += queue_data_record($urandom(), len, len);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input logic value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            CFG_SEGMENTED: seg_mode = value;
            CFG_START_EN:  start_en = value;
            CFG_FOOTER_EN: footer_en = value;
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic seg, input logic start, input logic footer);
        write_reg(CFG_SEGMENTED, seg);
        write_reg(CFG_START_EN, start);
        write_reg(CFG_FOOTER_EN, footer);
    endtask

    task automatic drain();
        while (pending_records.size() != 0 || s_tvalid || expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender: bursts of items with random gaps
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_records.size() != 0)
            begin
                next_record = pending_records.pop_front();
                s_tdata <= {next_record.data_byte, next_record.length, next_record.address};
                s_tuser <= next_record.opcode;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stretches of free flow, light, heavy and periodic stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 80);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_left % 3 == 0);
        endcase
    end

    // check output items first, then predict from the input item taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    failures++;
                    $display("%0t: expected no item, got char %h last %b error %b",
                             $time, m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    head_char = expected_chars.pop_front();
                    if (m_tdata != {1'b0, head_char.text_char} || m_tlast != head_char.last
                        || m_tuser != head_char.err)
                    begin
                        failures++;
                        $display("%0t: expected %h last %b err %b, got %h last %b err %b",
                                 $time, {1'b0, head_char.text_char}, head_char.last,
                                 head_char.err, m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_hex_text({s_tuser, s_tdata[31:0], s_tdata[39:32], s_tdata[47:40]});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // linear mode, reset settings
        queue_record(OP_DATA_START, 32'h0000_0000, 8'd0, 8'h00);
        queue_record(OP_DATA_START, 32'hFFFF_FFFF, 8'd255, 8'hFF);
        queue_record(OP_DATA_BYTE, 32'h0, 8'h0, 8'hFF);
        queue_record(OP_DATA_BYTE, 32'hFFFF_FFFF, 8'hFF, 8'h00);
        queue_record(OP_DATA_START, 32'h1234_5678, 8'd2, 8'h00);
        queue_record(OP_DATA_BYTE, 32'h0, 8'h0, 8'hA5);
        queue_record(OP_DATA_BYTE, 32'h0, 8'h0, 8'h5A);
        queue_record(OP_DATA_BYTE, 32'h0, 8'h0, 8'h3C);
        queue_record(OP_EXEC_START, 32'hFFFF_FFFF, 8'h0, 8'h0);
        queue_record(OP_EXEC_START, 32'h0000_0000, 8'h0, 8'h0);
        queue_record(OP_IGNORE, 32'h0, 8'h0, 8'h0);
        queue_record(OP_RESERVED_5, 32'h0, 8'h0, 8'h0);
        queue_record(OP_RESERVED_6, 32'h0, 8'h0, 8'h0);
        queue_record(OP_RESERVED_7, 32'h0, 8'h0, 8'h0);
        drain();

        // segmented mode: kept base, oversize segment, top segment, start and footer
        set_config(1'b1, 1'b1, 1'b1);
        queue_record(OP_DATA_START, 32'h1234_0000, 8'd1, 8'h0);
        queue_record(OP_DATA_BYTE, 32'h0, 8'h0, 8'h80);
        queue_record(OP_DATA_START, 32'h0010_0000, 8'd3, 8'h0);
        queue_record(OP_DATA_BYTE, 32'h0, 8'h0, 8'h11);
        queue_record(OP_DATA_START, 32'h000F_FFF0, 8'd1, 8'h0);
        queue_record(OP_DATA_BYTE, 32'h0, 8'h0, 8'h7E);
        queue_record(OP_EXEC_START, 32'h8000_0001, 8'h0, 8'h0);
        queue_record(OP_FINISH, 32'h0, 8'h0, 8'h0);
        drain();

        // linear, start and footer off; base forced again after finish
        set_config(1'b0, 1'b0, 1'b0);
        queue_record(OP_EXEC_START, 32'h0000_0001, 8'h0, 8'h0);
        queue_record(OP_FINISH, 32'h0, 8'h0, 8'h0);
        queue_record(OP_DATA_START, 32'h000F_0000, 8'd0, 8'h0);
        drain();

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_config(1'b0, 1'b1, 1'b1);
                1: set_config(1'b1, 1'b1, 1'b1);
                2: set_config(1'b1, 1'b0, 1'b0);
                default: set_config(1'($urandom()), 1'($urandom()), 1'($urandom()));
            endcase
            queue_random_records(61);
            drain();
        end

        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/ihw_pkg.sv
rtl/core/ihw_front.sv
rtl/core/ihw_queue.sv
rtl/core/ihw_back.sv
rtl/core/intel_hex_record_writer.sv
rtl/core/ihw_checker.sv
tb/intel_hex_record_writer_test.sv
